// File: hdl/wsht_pkg.sv
`timescale 1ns / 1ps

package wsht_pkg;

    // Stack size and coordinate width
    localparam int MAX_WINDOWS = 16;
    localparam int COORD_BITS  = 12;

    // Derived widths: window index, count (holds MAX_WINDOWS itself)
    localparam int IDX_W = $clog2(MAX_WINDOWS);
    localparam int CNT_W = $clog2(MAX_WINDOWS + 1);
    localparam int NUM_W = 5;

    // Item actions
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_CLICK = 1'b1;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_IGNORED = 2'd0,
        KIND_HIT     = 2'd1,
        KIND_LOADED  = 2'd2,
        KIND_DROPPED = 2'd3
    } kind_t;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_FINISH
    } state_t;

    // Operation that the datapath carries out in its commit cycle
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_DROP,
        OP_HIT,
        OP_MISS
    } op_t;

    // One stored rectangle, all bounds inclusive
    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] bottom;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] top;
    } rect_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        op_t  op;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_click;
        logic full;
        logic found;
    } stat_t;

endpackage

// File: hdl/wsht_ctrl.sv
`timescale 1ns / 1ps

module wsht_ctrl
    import wsht_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.op      = OP_NONE;
        busy        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // Take the word and run the compare cells on it
                cmd.capture = start;
                if (start)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                busy = 1'b1;
                if (stat.is_click)
                begin
                    cmd.op = stat.found ? OP_HIT : OP_MISS;
                end
                else
                begin
                    cmd.op = stat.full ? OP_DROP : OP_LOAD;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/wsht_datapath.sv
`timescale 1ns / 1ps

module wsht_datapath
    import wsht_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic                  action,
    input  logic [COORD_BITS-1:0] left,
    input  logic [COORD_BITS-1:0] bottom,
    input  logic [COORD_BITS-1:0] right,
    input  logic [COORD_BITS-1:0] top,
    input  logic [COORD_BITS-1:0] click_x,
    input  logic [COORD_BITS-1:0] click_y,
    output logic                  done,
    output logic [1:0]            kind,
    output logic [NUM_W-1:0]      window_number
);

    // Stored windows, indexed by window number minus one
    rect_t            rects_reg [MAX_WINDOWS];
    // Stacking order: entry 0 is the bottom window
    logic [IDX_W-1:0] z_reg [MAX_WINDOWS];
    logic [CNT_W-1:0] count_reg;

    // Captured word
    logic             action_reg;
    rect_t            in_rect_reg;
    logic [MAX_WINDOWS-1:0] hit_win_reg;
    logic [MAX_WINDOWS-1:0] hit_win_next;

    // Result registers
    logic             done_reg;
    kind_t            kind_reg;
    logic [NUM_W-1:0] number_reg;

    logic [MAX_WINDOWS-1:0] hit_pos;
    logic             found;
    logic [IDX_W-1:0] pick;
    logic [IDX_W-1:0] load_idx;

    assign load_idx = count_reg[IDX_W-1:0];

    // One compare cell per stored window
    always_comb
    begin
        for (int w = 0; w < MAX_WINDOWS; w++)
        begin
            hit_win_next[w] = (rects_reg[w].left <= click_x) && (click_x <= rects_reg[w].right)
                && (rects_reg[w].bottom <= click_y) && (click_y <= rects_reg[w].top);
        end
    end

    // Map window hits onto stack positions that are occupied
    always_comb
    begin
        for (int p = 0; p < MAX_WINDOWS; p++)
        begin
            hit_pos[p] = hit_win_reg[z_reg[p]] && (count_reg > CNT_W'(p));
        end
    end

    // Priority pick: the highest occupied position wins
    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        for (int p = 0; p < MAX_WINDOWS; p++)
        begin
            if (hit_pos[p])
            begin
                found = 1'b1;
                pick  = IDX_W'(p);
            end
        end
    end

    assign stat.is_click = (action_reg == ACT_CLICK);
    assign stat.full     = (count_reg == CNT_W'(MAX_WINDOWS));
    assign stat.found    = found;

    // Captured word and compare results
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg         <= action;
            in_rect_reg.left   <= left;
            in_rect_reg.bottom <= bottom;
            in_rect_reg.right  <= right;
            in_rect_reg.top    <= top;
            hit_win_reg        <= hit_win_next;
        end
    end

    // Window store and stacking order
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            rects_reg[load_idx] <= in_rect_reg;
            z_reg[load_idx]     <= load_idx;
        end
        else if (cmd.op == OP_HIT)
        begin
            // Close the gap above the picked window and put it on top
            for (int k = 0; k < MAX_WINDOWS; k++)
            begin
                if ((count_reg > CNT_W'(k + 1)) && (pick <= IDX_W'(k)))
                begin
                    z_reg[k] <= z_reg[(k + 1) % MAX_WINDOWS];
                end
                else if (count_reg == CNT_W'(k + 1))
                begin
                    z_reg[k] <= z_reg[pick];
                end
            end
        end
    end

    // Window count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.op == OP_LOAD)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.op != OP_NONE);
        end
    end

    // Result word
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                kind_reg   <= KIND_LOADED;
                number_reg <= '0;
            end
            OP_DROP:
            begin
                kind_reg   <= KIND_DROPPED;
                number_reg <= '0;
            end
            OP_HIT:
            begin
                kind_reg   <= KIND_HIT;
                number_reg <= NUM_W'(z_reg[pick]) + NUM_W'(1);
            end
            OP_MISS:
            begin
                kind_reg   <= KIND_IGNORED;
                number_reg <= '0;
            end
            default:
            begin
                kind_reg   <= kind_reg;
                number_reg <= number_reg;
            end
        endcase
    end

    assign done          = done_reg;
    assign kind          = kind_reg;
    assign window_number = number_reg;

endmodule

// File: hdl/window_stack_hit_test.sv
// The result word is registered and strobed on done after its item's commit step.
// Each item has a capture step that runs all compare cells in parallel, then a commit
// step with the priority pick and move to top; start is not taken while busy is high.
// The receiver cannot stall; each result is shown for exactly one cycle on done.
// Reset (asynchronous, active low) empties the stack and clears the controller and
// strobe; rectangle and ordering storage keep no reset value.
`timescale 1ns / 1ps

module window_stack_hit_test
    import wsht_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  action,
    input  logic [COORD_BITS-1:0] left,
    input  logic [COORD_BITS-1:0] bottom,
    input  logic [COORD_BITS-1:0] right,
    input  logic [COORD_BITS-1:0] top,
    input  logic [COORD_BITS-1:0] click_x,
    input  logic [COORD_BITS-1:0] click_y,
    output logic                  done,
    output logic [1:0]            kind,
    output logic [NUM_W-1:0]      window_number
);

    cmd_t  cmd;
    stat_t stat;

    // Sequencer
    wsht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Window store, compare cells and stacking order
    wsht_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .action        (action),
        .left          (left),
        .bottom        (bottom),
        .right         (right),
        .top           (top),
        .click_x       (click_x),
        .click_y       (click_y),
        .done          (done),
        .kind          (kind),
        .window_number (window_number)
    );

endmodule

// File: hdl/wsht_checker.sv
`timescale 1ns / 1ps

module wsht_checker
    import wsht_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input logic [1:0]       kind,
    input logic [NUM_W-1:0] window_number
);

    // An accepted word always yields its result on done after its finish state
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted word gave no result");

    // No result appears without an item having been worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without an item in progress");

    // The block is busy for a single cycle per word
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // A hit names a window, every other kind carries zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (kind == KIND_HIT)) |-> (window_number != '0))
        else $error("hit without a window number");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (kind != KIND_HIT)) |-> (window_number == '0))
        else $error("window number on a result that is not a hit");

endmodule

bind window_stack_hit_test wsht_checker u_wsht_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .kind          (kind),
    .window_number (window_number)
);
